@@ hw/rtl/ilid_pkg.sv @@
`default_nettype none
package ilid_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [FUNC_W-1:0] FN_READ       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_HEAD   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_TAIL   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_AT     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_AT     = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic [IDX_W-1:0]  at;
        logic [VAL_W-1:0]  value;
    } cell_ctrl_t;

    // per-command outcome from the controller
    typedef struct packed {
        logic              is_read;
        logic              read_ok;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } cmd_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/ilid_cell.sv @@
`default_nettype none
module ilid_cell (
    input  wire logic                            clk,
    input  wire logic [ilid_pkg::IDX_W-1:0]      idx,
    input  wire ilid_pkg::cell_ctrl_t            ctrl,
    input  wire logic [ilid_pkg::VAL_W-1:0]      lower,
    input  wire logic [ilid_pkg::VAL_W-1:0]      upper,
    input  wire logic [ilid_pkg::IDX_W-1:0]      rd_idx,
    output logic [ilid_pkg::VAL_W-1:0]           entry,
    output logic [ilid_pkg::VAL_W-1:0]           rd_data
);

    logic [ilid_pkg::VAL_W-1:0] entry_reg;
    logic [ilid_pkg::VAL_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_up)
        begin
            if (idx == ctrl.at)
                entry_next = ctrl.value;
            else if (idx > ctrl.at)
                entry_next = lower;
        end
        else if (ctrl.shift_down)
        begin
            if (idx >= ctrl.at)
                entry_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_data = (idx == rd_idx) ? entry_reg : '0;

endmodule
`default_nettype wire

@@ hw/rtl/ilid_ctrl.sv @@
`default_nettype none
module ilid_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire logic [ilid_pkg::FUNC_W-1:0]     func,
    input  wire logic [ilid_pkg::POS_W-1:0]      position,
    input  wire logic [ilid_pkg::VAL_W-1:0]      value,
    output ilid_pkg::cell_ctrl_t                 ctrl,
    output ilid_pkg::cmd_res_t                   res
);

    logic [ilid_pkg::CNT_W-1:0] length_reg;
    logic [ilid_pkg::CNT_W-1:0] length_next;
    logic                       full;
    logic                       ins;
    logic                       del;
    logic [ilid_pkg::CNT_W-1:0] ins_at;

    assign full = (length_reg >= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY));

    always_comb
    begin
        ins         = 1'b0;
        del         = 1'b0;
        ins_at      = '0;
        res.is_read = 1'b0;
        res.read_ok = 1'b0;
        res.status  = ilid_pkg::ST_DONE;
        unique case (func)
            ilid_pkg::FN_READ:
            begin
                res.is_read = 1'b1;
                if (position < length_reg)
                    res.read_ok = 1'b1;
                else
                    res.status = ilid_pkg::ST_RANGE;
            end
            ilid_pkg::FN_INS_HEAD:
            begin
                if (full)
                    res.status = ilid_pkg::ST_FULL;
                else
                    ins = 1'b1;
            end
            ilid_pkg::FN_INS_TAIL:
            begin
                ins_at = length_reg;
                if (full)
                    res.status = ilid_pkg::ST_FULL;
                else
                    ins = 1'b1;
            end
            ilid_pkg::FN_INS_AT:
            begin
                ins_at = position;
                // range test goes before the full test
                if (position > length_reg)
                    res.status = ilid_pkg::ST_RANGE;
                else if (full)
                    res.status = ilid_pkg::ST_FULL;
                else
                    ins = 1'b1;
            end
            ilid_pkg::FN_DEL_AT:
            begin
                if (position >= length_reg)
                    res.status = ilid_pkg::ST_RANGE;
                else
                    del = 1'b1;
            end
            default:
            begin
                res.status = ilid_pkg::ST_RANGE;
            end
        endcase

        length_next = length_reg;
        if (ins)
            length_next = length_reg + ilid_pkg::CNT_W'(1);
        else if (del)
            length_next = length_reg - ilid_pkg::CNT_W'(1);
        res.count = length_next;

        ctrl.shift_up   = fire && ins;
        ctrl.shift_down = fire && del;
        ctrl.at         = del ? position[ilid_pkg::IDX_W-1:0] : ins_at[ilid_pkg::IDX_W-1:0];
        ctrl.value      = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else if (fire)
            length_reg <= length_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/indexed_list_insert_delete_top.sv @@
// A command's result is captured in the output register in the cycle after it is accepted.
// One command per cycle while the output register is empty or being taken; the whole row of cells shifts at once.
// A new command is taken while the previous result is being taken (m_tready high).
// Reset clears the list length and the output valid; cell contents are undefined until written.
`default_nettype none
module indexed_list_insert_delete_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // func[2:0], position[9:3], value[41:10], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // read_value[31:0], status[33:32], count[40:34], zero pad
);

    localparam int N = ilid_pkg::CAPACITY;

    logic                         fire;
    logic [ilid_pkg::FUNC_W-1:0]  func;
    logic [ilid_pkg::POS_W-1:0]   position;
    logic [ilid_pkg::VAL_W-1:0]   value;
    ilid_pkg::cell_ctrl_t         ctrl;
    ilid_pkg::cmd_res_t           res;

    logic [ilid_pkg::VAL_W-1:0]   entry   [N];
    logic [ilid_pkg::VAL_W-1:0]   rd_data [N];
    logic [ilid_pkg::VAL_W-1:0]   rd_sel;
    logic [ilid_pkg::VAL_W-1:0]   rd_value;

    logic                         out_valid_reg;
    logic [ilid_pkg::VAL_W-1:0]   out_value_reg;
    logic [ilid_pkg::STAT_W-1:0]  out_status_reg;
    logic [ilid_pkg::CNT_W-1:0]   out_count_reg;

    assign func     = s_tdata[2:0];
    assign position = s_tdata[9:3];
    assign value    = s_tdata[41:10];

    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    ilid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .func     (func),
        .position (position),
        .value    (value),
        .ctrl     (ctrl),
        .res      (res)
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [ilid_pkg::VAL_W-1:0] lower;
        logic [ilid_pkg::VAL_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = entry[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = entry[i+1];
        end

        ilid_cell u_cell (
            .clk     (clk),
            .idx     (ilid_pkg::IDX_W'(i)),
            .ctrl    (ctrl),
            .lower   (lower),
            .upper   (upper),
            .rd_idx  (position[ilid_pkg::IDX_W-1:0]),
            .entry   (entry[i]),
            .rd_data (rd_data[i])
        );
    end

    // one-hot select: only the addressed cell drives nonzero
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < N; i++)
            rd_sel = rd_sel | rd_data[i];
    end

    always_comb
    begin
        if (!res.is_read)
            rd_value = '0;
        else if (res.read_ok)
            rd_value = rd_sel;
        else
            rd_value = '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_value_reg  <= rd_value;
            out_status_reg <= res.status;
            out_count_reg  <= res.count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_status_reg, out_value_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_count_reg <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY)))
        else $error("list length above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg == ilid_pkg::ST_FULL)
            |-> (out_count_reg == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY)))
        else $error("full status with list not full");

    a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (!ctrl.shift_up && !ctrl.shift_down))
        else $error("cells shifted without a transaction");

    a_single_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.shift_up && ctrl.shift_down))
        else $error("cells told to shift both ways");

endmodule
`default_nettype wire
